>>> rtl/sfr_pkg.sv
// shared types and constants of the serial frame receiver
`default_nettype none

package sfr_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int LEN_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 3;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [BYTE_W-1:0] START_BYTE  = 8'h2A;
  localparam logic [BYTE_W-1:0] SECOND_BYTE = 8'h40;

  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_CODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_CODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_LENGTH  = 3'd3;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_STAR,
    PH_CODE,
    PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_HOLD
  } bstate_t;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_OK,
    OP_ERR
  } cmd_op_t;

  // write: cnt is the store address; ok/err: cnt is the byte count
  typedef struct packed {
    cmd_op_t           op;
    logic              kind;
    logic [CNT_W-1:0]  cnt;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

>>> rtl/serial_frame_receiver_checksum.sv
// top level of the serial frame receiver with additive checksum
// bytes are taken one per cycle while the command queue has room
// a good frame's command passes the queue; each result is read from the single-port payload
// store in the emitter's read state, then held; an error result is loaded on its pop
// synchronous active-low reset clears parser, queue and emitter control, store is not cleared
`default_nettype none

module serial_frame_receiver_checksum
  import sfr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [BYTE_W-1:0]    in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_packet_kind,
  output logic [BYTE_W-1:0]         out_payload_byte,
  output logic                      out_status,
  output logic                      out_last,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data
);

  fifo_stat_t fifo_stat;
  logic       push, pop;
  cmd_t       push_cmd, pop_cmd;

  sfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fifo_stat  (fifo_stat),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  sfr_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .stat     (fifo_stat)
  );

  sfr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .fifo_stat        (fifo_stat),
    .pop_cmd          (pop_cmd),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_packet_kind  (out_packet_kind),
    .out_payload_byte (out_payload_byte),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_stat.empty)
    else $error("emitter popped an empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_stat.full)
    else $error("parser pushed into a full queue");

  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_last && (out_payload_byte == '0)))
    else $error("malformed error result");

  a_burst_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> ##1 (out_valid && !out_status))
    else $error("burst not continued after a non-final result");

endmodule

`default_nettype wire

>>> rtl/sfr_front.sv
// frame parser: start pair hunt, code decode, payload sum and command issue
`default_nettype none

module sfr_front
  import sfr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [BYTE_W-1:0]    in_rx_byte,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data,
  input  wire fifo_stat_t           fifo_stat,
  output logic                      push,
  output cmd_t                      push_cmd
);

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               kind_r, kind_nxt;
  logic [CNT_W-1:0]   len_r, len_nxt;
  logic [BYTE_W-1:0]  sum_r, sum_nxt;

  logic [BYTE_W-1:0]  sensor_code_r, board_code_r;
  logic [LEN_W-1:0]   sensor_len_r, board_len_r;

  logic               accept;
  logic               sel_sensor, sel_board;
  logic [LEN_W-1:0]   raw_len;
  logic [CNT_W-1:0]   clamp_len;
  logic               in_payload;

  assign in_ready  = !fifo_stat.full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  assign sel_sensor = (in_rx_byte == sensor_code_r);
  assign sel_board  = !sel_sensor && (in_rx_byte == board_code_r);
  assign raw_len    = sel_sensor ? sensor_len_r : board_len_r;
  assign clamp_len  = ({{(32-LEN_W){1'b0}}, raw_len} > 32'(MAX_PAYLOAD)) ?
                      CNT_W'(MAX_PAYLOAD) : CNT_W'(raw_len);
  assign in_payload = (count_r < len_r);

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    kind_nxt  = kind_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    if (accept) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (in_rx_byte == START_BYTE) phase_nxt = PH_STAR;
        end
        PH_STAR: begin
          phase_nxt = (in_rx_byte == SECOND_BYTE) ? PH_CODE : PH_HUNT;
        end
        PH_CODE: begin
          if ((sel_sensor || sel_board) && (clamp_len != '0)) begin
            kind_nxt  = sel_board;
            len_nxt   = clamp_len;
            count_nxt = '0;
            sum_nxt   = '0;
            phase_nxt = PH_DATA;
          end else begin
            len_nxt   = '0;
            phase_nxt = PH_HUNT;
          end
        end
        PH_DATA: begin
          if (in_payload) begin
            sum_nxt   = sum_r + in_rx_byte;
            count_nxt = count_r + 1'b1;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    push          = 1'b0;
    push_cmd.op   = OP_WRITE;
    push_cmd.kind = kind_r;
    push_cmd.cnt  = count_r;
    push_cmd.data = in_rx_byte;
    unique case (phase_r)
      PH_DATA: begin
        push = accept;
        if (!in_payload) begin
          push_cmd.op = (sum_r == in_rx_byte) ? OP_OK : OP_ERR;
        end
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      count_r       <= '0;
      kind_r        <= 1'b0;
      len_r         <= '0;
      sum_r         <= '0;
      sensor_code_r <= 8'd1;
      board_code_r  <= 8'd2;
      sensor_len_r  <= 6'd8;
      board_len_r   <= 6'd16;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      kind_r  <= kind_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SENSOR_CODE:   sensor_code_r <= cfg_data;
          CFG_BOARD_CODE:    board_code_r  <= cfg_data;
          CFG_SENSOR_LENGTH: sensor_len_r  <= cfg_data[LEN_W-1:0];
          CFG_BOARD_LENGTH:  board_len_r   <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/sfr_cmd_fifo.sv
// short command queue between parser and burst emitter
`default_nettype none

module sfr_cmd_fifo
  import sfr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output fifo_stat_t stat
);

  cmd_t               entry_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   fill_r;

  assign pop_cmd    = entry_r[rd_ptr_r];
  assign stat.full  = (fill_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (fill_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      fill_r <= fill_r + 1'b1;
      else if (pop && !push) fill_r <= fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_cmd;
  end

endmodule

`default_nettype wire

>>> rtl/sfr_back.sv
// payload store and result burst emitter
`default_nettype none

module sfr_back
  import sfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fifo_stat_t        fifo_stat,
  input  wire cmd_t              pop_cmd,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_packet_kind,
  output logic [BYTE_W-1:0]      out_payload_byte,
  output logic                   out_status,
  output logic                   out_last
);

  bstate_t           state_r, state_nxt;
  logic [CNT_W-1:0]  idx_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              kind_r;
  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];

  logic              kind_out_r;
  logic [BYTE_W-1:0] payload_out_r;
  logic              status_out_r;
  logic              last_out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!fifo_stat.empty) begin
          unique case (pop_cmd.op)
            OP_OK:   state_nxt = B_READ;
            OP_ERR:  state_nxt = B_HOLD;
            default: state_nxt = B_IDLE;
          endcase
        end
      end
      B_READ: state_nxt = B_HOLD;
      B_HOLD: begin
        if (out_ready) state_nxt = last_out_r ? B_IDLE : B_READ;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      B_IDLE:  pop = !fifo_stat.empty;
      B_HOLD:  out_valid = 1'b1;
      default: ;
    endcase
  end

  assign out_packet_kind  = kind_out_r;
  assign out_payload_byte = payload_out_r;
  assign out_status       = status_out_r;
  assign out_last         = last_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
      kind_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop && (pop_cmd.op == OP_OK)) begin
        idx_r  <= '0;
        cnt_r  <= pop_cmd.cnt;
        kind_r <= pop_cmd.kind;
      end else if ((state_r == B_HOLD) && out_ready) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // store write, registered store read and error result load
  always_ff @(posedge clk) begin
    if (pop && (pop_cmd.op == OP_WRITE)) begin
      mem[pop_cmd.cnt[ADDR_W-1:0]] <= pop_cmd.data;
    end
    if (pop && (pop_cmd.op == OP_ERR)) begin
      kind_out_r    <= pop_cmd.kind;
      payload_out_r <= '0;
      status_out_r  <= 1'b1;
      last_out_r    <= 1'b1;
    end else if (state_r == B_READ) begin
      kind_out_r    <= kind_r;
      payload_out_r <= mem[idx_r[ADDR_W-1:0]];
      status_out_r  <= 1'b0;
      last_out_r    <= ((idx_r + 1'b1) == cnt_r);
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_serial_frame_receiver_checksum.sv
// testbench of the serial frame receiver: random framed byte streams checked against a deframer
`timescale 1ns / 100ps

module tb_serial_frame_receiver_checksum;
  import sfr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 300;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic              status;
    logic              is_last;
  } frame_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_packet_kind;
  logic [BYTE_W-1:0]    out_payload_byte;
  logic                 out_status;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;

  serial_frame_receiver_checksum u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_packet_kind  (out_packet_kind),
    .out_payload_byte (out_payload_byte),
    .out_status       (out_status),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [BYTE_W-1:0] rx_stream[$];
  frame_result_t     pending_results[$];
  int                mismatches = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                hold_asks = 0;
  int                frame_bytes = 0;

  // deframer state and register copies
  logic [BYTE_W-1:0] sensor_code, board_code;
  logic [LEN_W-1:0]  sensor_len, board_len;
  phase_t            parse_st;
  int                taken, frame_len;
  logic              cur_kind;
  logic [BYTE_W-1:0] run_sum;
  logic [BYTE_W-1:0] payload_mem [MAX_PAYLOAD];

  function automatic void deframer_reset();
    sensor_code = 8'd1;
    board_code  = 8'd2;
    sensor_len  = 6'd8;
    board_len   = 6'd16;
    parse_st    = PH_HUNT;
    taken       = 0;
    frame_len   = 0;
    cur_kind    = 1'b0;
    run_sum     = '0;
  endfunction

  function automatic void deframer_write_reg(input logic [CFG_IDX_W-1:0] idx,
                                             input logic [BYTE_W-1:0] val);
    case (idx)
      CFG_SENSOR_CODE:   sensor_code = val;
      CFG_BOARD_CODE:    board_code  = val;
      CFG_SENSOR_LENGTH: sensor_len  = val[LEN_W-1:0];
      CFG_BOARD_LENGTH:  board_len   = val[LEN_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
    int n;
    frame_result_t r;
    case (parse_st)
      PH_HUNT: begin
        if (b == START_BYTE) parse_st = PH_STAR;
      end
      PH_STAR: parse_st = (b == SECOND_BYTE) ? PH_CODE : PH_HUNT;
      PH_CODE: begin
        n = 0;
        if (b == sensor_code) begin
          cur_kind = 1'b0;
          n = sensor_len;
        end else if (b == board_code) begin
          cur_kind = 1'b1;
          n = board_len;
        end
        if (n > MAX_PAYLOAD) n = MAX_PAYLOAD;
        if (n == 0) begin
          parse_st  = PH_HUNT;
          frame_len = 0;
        end else begin
          frame_len = n;
          taken     = 0;
          run_sum   = '0;
          parse_st  = PH_DATA;
        end
      end
      default: begin
        if (taken < frame_len) begin
          payload_mem[taken] = b;
          run_sum = run_sum + b;
          taken++;
        end else begin
          parse_st = PH_HUNT;
          if (run_sum == b) begin
            for (int k = 0; k < taken; k++) begin
              r = '{cur_kind, payload_mem[k], 1'b0, k == taken - 1};
              pending_results.push_back(r);
            end
          end else begin
            r = '{cur_kind, 8'h00, 1'b1, 1'b1};
            pending_results.push_back(r);
          end
        end
      end
    endcase
  endfunction

  // sender: one request per accepted byte
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) deframe_byte(in_rx_byte);
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (rx_stream.size() == 0) begin
          in_valid <= 1'b0;
        end else if ($urandom_range(0, 99) < send_idle_pct) begin
          in_valid <= 1'b0;
          gap_left <= $urandom_range(0, 13);
        end else begin
          in_valid   <= 1'b1;
          in_rx_byte <= rx_stream.pop_front();
        end
      end
    end
  end

  // receiver backpressure
  int hold_left = 0;
  int stall_left = 0;
  int hold_served = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      hold_left  <= 0;
      stall_left <= 0;
    end else if (hold_served != hold_asks) begin
      out_ready   <= 1'b0;
      hold_left   <= LONG_HOLD;
      hold_served <= hold_asks;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < recv_idle_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    frame_result_t seen, want;
    if (rst_n && out_valid && out_ready) begin
      seen = '{out_packet_kind, out_payload_byte, out_status, out_last};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d byte=%02h status=%0d last=%0d",
                   seen.kind, seen.data, seen.status, seen.is_last);
      end else begin
        want = pending_results.pop_front();
        if (seen.kind !== want.kind || seen.data !== want.data ||
            seen.status !== want.status || seen.is_last !== want.is_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: kind %0d/%0d byte %02h/%02h status %0d/%0d last %0d/%0d",
                     want.kind, seen.kind, want.data, seen.data,
                     want.status, seen.status, want.is_last, seen.is_last);
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    deframer_write_reg(idx, val);
  endtask

  task automatic wait_drained();
    while (rx_stream.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  function automatic void push_frame(input logic [BYTE_W-1:0] code, input int n,
                                     input bit good);
    logic [BYTE_W-1:0] sum, b;
    sum = '0;
    rx_stream.push_back(START_BYTE);
    rx_stream.push_back(SECOND_BYTE);
    rx_stream.push_back(code);
    for (int i = 0; i < n; i++) begin
      b = rand_byte();
      sum = sum + b;
      rx_stream.push_back(b);
    end
    rx_stream.push_back(good ? sum : sum + BYTE_W'($urandom_range(1, 255)));
    frame_bytes += n + 4;
  endfunction

  function automatic int frame_size(input logic [BYTE_W-1:0] code);
    int n;
    n = (code == sensor_code) ? sensor_len : board_len;
    return (n > MAX_PAYLOAD) ? MAX_PAYLOAD : n;
  endfunction

  function automatic void push_noise();
    int cnt;
    cnt = $urandom_range(1, 6);
    for (int i = 0; i < cnt; i++) begin
      case ($urandom_range(0, 6))
        0, 1:    rx_stream.push_back(START_BYTE);
        2:       rx_stream.push_back(SECOND_BYTE);
        default: rx_stream.push_back(rand_byte());
      endcase
    end
  endfunction

  function automatic void push_random_traffic(input int budget);
    logic [BYTE_W-1:0] code;
    int n, start;
    start = frame_bytes;
    while (frame_bytes - start < budget) begin
      case ($urandom_range(0, 9))
        7: begin
          code = BYTE_W'($urandom);
          push_frame(code, $urandom_range(0, 6), $urandom_range(0, 1));
        end
        8: push_noise();
        9: begin
          code = $urandom_range(0, 1) ? board_code : sensor_code;
          n = frame_size(code);
          push_frame(code, (n > 0) ? $urandom_range(0, n - 1) : 0, 1'b1);
        end
        default: begin
          code = $urandom_range(0, 1) ? board_code : sensor_code;
          push_frame(code, frame_size(code), $urandom_range(0, 3) != 0);
        end
      endcase
    end
  endfunction

  function automatic logic [BYTE_W-1:0] rand_length();
    logic [LEN_W-1:0] len;
    len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, 63))
                                      : LEN_W'($urandom_range(1, 12));
    return {2'($urandom), len};
  endfunction

  initial begin
    logic [BYTE_W-1:0] sc, bc;
    deframer_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 10;
    recv_idle_pct = 10;

    // reset values: noise, broken start pair, unknown code, one good sensor frame
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(START_BYTE);
    rx_stream.push_back(START_BYTE);
    rx_stream.push_back(SECOND_BYTE);
    rx_stream.push_back(8'h01);
    rx_stream.push_back(START_BYTE);
    rx_stream.push_back(SECOND_BYTE);
    rx_stream.push_back(8'h07);
    push_frame(8'h01, 8, 1'b1);
    wait_drained();

    // extreme codes and lengths, plus a write to an unused index
    write_reg(CFG_SENSOR_CODE, 8'h00);
    write_reg(CFG_BOARD_CODE, 8'hFF);
    write_reg(CFG_SENSOR_LENGTH, 8'd1);
    write_reg(CFG_BOARD_LENGTH, 8'd32);
    write_reg(CFG_UNUSED, 8'h3F);
    push_frame(8'h00, 1, 1'b1);
    push_frame(8'h00, 1, 1'b0);
    push_random_traffic(50);
    wait_drained();

    // equal codes pick the sensor kind; long receiver hold fills the block
    write_reg(CFG_SENSOR_CODE, 8'h55);
    write_reg(CFG_BOARD_CODE, 8'h55);
    write_reg(CFG_SENSOR_LENGTH, 8'd3);
    write_reg(CFG_BOARD_LENGTH, 8'd5);
    push_frame(8'h55, 3, 1'b1);
    push_random_traffic(50);
    hold_asks++;
    wait_drained();

    // zero length aborts, oversize length saturates
    write_reg(CFG_SENSOR_CODE, START_BYTE);
    write_reg(CFG_BOARD_CODE, SECOND_BYTE);
    write_reg(CFG_SENSOR_LENGTH, 8'd0);
    write_reg(CFG_BOARD_LENGTH, 8'd63);
    rx_stream.push_back(START_BYTE);
    rx_stream.push_back(SECOND_BYTE);
    rx_stream.push_back(START_BYTE);
    push_random_traffic(40);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct = (ph == 4) ? 0 : $urandom_range(0, 20);
      recv_idle_pct = (ph == 4) ? 0 : $urandom_range(0, 20);
      sc = ($urandom_range(0, 3) == 0) ? 8'hFF : BYTE_W'($urandom);
      bc = ($urandom_range(0, 3) == 0) ? 8'h00 : BYTE_W'($urandom);
      write_reg(CFG_SENSOR_CODE, sc);
      write_reg(CFG_BOARD_CODE, bc);
      write_reg(CFG_SENSOR_LENGTH, rand_length());
      write_reg(CFG_BOARD_LENGTH, rand_length());
      if (ph == 2) write_reg(CFG_UNUSED + 3'd1, BYTE_W'($urandom));
      push_random_traffic(40);
      if (ph == 1) hold_asks++;
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
